### hdl/npc_pkg.sv
// Shared types and constants for the nearest palette color pair block.
package npc_pkg;

  localparam int ROM_SIZE    = 23;
  localparam int IDX_W       = 5;
  localparam int DIST_W      = 10;
  // one extra bit so an empty slot sorts after every real distance
  localparam int CAND_W      = DIST_W + 1;
  localparam int TREE_LEAVES = 32;
  localparam int TREE_LEVELS = 5;
  localparam logic [DIST_W-1:0] MAX_DIST = 10'd1020;

  localparam logic [31:0] PALETTE_ROM [0:ROM_SIZE-1] = '{
    32'hFFFFFFFF, 32'h7F7F7FFF, 32'h3E3E4DFF, 32'h000000FF, 32'h000000FF,
    32'h0000007F, 32'h00000000, 32'hFF0000FF, 32'h990F02FF, 32'hFFC0CBFF,
    32'h8C0000FF, 32'h00FF00FF, 32'h172808FF, 32'h3C4C24FF, 32'h32DC32FF,
    32'h0000FFFF, 32'h82C8E5FF, 32'h00A1CEFF, 32'h1A224CFF, 32'h281E5DFF,
    32'hFFF200FF, 32'hFFBF00FF, 32'h895129FF
  };

  typedef struct packed {
    logic [CAND_W-1:0] distance;
    logic [IDX_W-1:0]  idx;
  } cand_t;

  typedef struct packed {
    cand_t first;
    cand_t second;
  } pair_t;

  localparam cand_t EMPTY_CAND = '{distance: '1, idx: '0};

endpackage

### hdl/nearest_palette_color_pair.sv
// Top level: three-stage pipeline (pixel, distances, result) with valid/ready flow control.
// Finds the nearest and second-nearest entries of a fixed 23-color palette to an RGBA pixel
// under L1 distance, ties going to the earlier entry, and flags a blend when
// 4*runner-up distance < 9*nearest distance. One pixel is accepted per cycle, and each
// result passes an input register, a register holding all palette distances, and the
// result register before it is presented. A stalled output backs up through the stages;
// a pixel is still accepted while any stage is free. PALETTE_ENTRIES sets how many
// leading palette entries are searched, capped at the 23 held in ROM.
module nearest_palette_color_pair #(
  parameter int PALETTE_ENTRIES = 23
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_pixel_rgba,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_nearest_index,
  output logic [4:0]  out_runner_up_index,
  output logic        out_blend_flag,
  output logic [9:0]  out_nearest_distance
);

  localparam int NUM_ENTRIES =
    (PALETTE_ENTRIES < npc_pkg::ROM_SIZE) ? PALETTE_ENTRIES : npc_pkg::ROM_SIZE;

  logic        s1_vld_r, s1_vld_nxt;
  logic [31:0] pix_r;
  logic        s2_vld_r, s2_vld_nxt;
  logic        out_vld_r, out_vld_nxt;
  logic        s1_rdy, s2_rdy, s3_rdy;

  logic [NUM_ENTRIES-1:0][npc_pkg::DIST_W-1:0] dist_c;
  logic [NUM_ENTRIES-1:0][npc_pkg::DIST_W-1:0] dist_r;
  npc_pkg::pair_t                              best_c;

  logic [npc_pkg::DIST_W-1:0] d1_c, d2_c;
  logic [13:0]                d1_x9_c;
  logic [13:0]                d2_x4_c;
  logic                       blend_c;

  logic [4:0]  nearest_idx_r;
  logic [4:0]  runner_idx_r;
  logic        blend_r;
  logic [9:0]  nearest_dist_r;

  npc_dist #(.NUM_ENTRIES(NUM_ENTRIES)) u_dist (
    .pixel    (pix_r),
    .dist_vec (dist_c)
  );

  npc_top2 #(.NUM_ENTRIES(NUM_ENTRIES)) u_top2 (
    .dist_vec (dist_r),
    .best     (best_c)
  );

  assign s3_rdy   = !out_vld_r || out_ready;
  assign s2_rdy   = !s2_vld_r || s3_rdy;
  assign s1_rdy   = !s1_vld_r || s2_rdy;
  assign in_ready = s1_rdy;

  assign s1_vld_nxt  = s1_rdy ? in_valid : s1_vld_r;
  assign s2_vld_nxt  = s2_rdy ? s1_vld_r : s2_vld_r;
  assign out_vld_nxt = s3_rdy ? s2_vld_r : out_vld_r;

  // an empty nearest slot cannot occur with two or more entries; kept for safety
  assign d1_c = (best_c.first.distance > npc_pkg::CAND_W'(npc_pkg::MAX_DIST)) ?
                '0 : best_c.first.distance[npc_pkg::DIST_W-1:0];
  assign d2_c = best_c.second.distance[npc_pkg::DIST_W-1:0];
  assign d1_x9_c = {1'b0, d1_c, 3'b000} + {4'b0000, d1_c};
  assign d2_x4_c = {2'b00, d2_c, 2'b00};
  assign blend_c = (best_c.second.distance <= npc_pkg::CAND_W'(npc_pkg::MAX_DIST)) &&
                   (d2_x4_c < d1_x9_c);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      s2_vld_r  <= s2_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_valid) begin
      pix_r <= in_pixel_rgba;
    end
    if (s2_rdy && s1_vld_r) begin
      dist_r <= dist_c;
    end
    if (s3_rdy && s2_vld_r) begin
      nearest_idx_r  <= best_c.first.idx;
      runner_idx_r   <= best_c.second.idx;
      blend_r        <= blend_c;
      nearest_dist_r <= d1_c;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_nearest_index    = nearest_idx_r;
  assign out_runner_up_index  = runner_idx_r;
  assign out_blend_flag       = blend_r;
  assign out_nearest_distance = nearest_dist_r;

  // input stalls only when every stage holds an item
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_vld_r && s2_vld_r && out_vld_r))
    else $error("input stalled with a free pipeline stage");

  a_pair_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_nearest_index != out_runner_up_index))
    else $error("nearest and runner-up indexes match");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_nearest_index < 5'(NUM_ENTRIES) &&
                   out_runner_up_index < 5'(NUM_ENTRIES)))
    else $error("result index beyond searched palette");

  a_exact_no_blend: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_blend_flag) |-> (out_nearest_distance != 10'd0))
    else $error("blend flagged on an exact match");

endmodule

### hdl/npc_dist.sv
// L1 distance from one pixel to every searched palette entry.
module npc_dist #(
  parameter int NUM_ENTRIES = 23
) (
  input  logic [31:0]                                  pixel,
  output logic [NUM_ENTRIES-1:0][npc_pkg::DIST_W-1:0] dist_vec
);

  function automatic logic [npc_pkg::DIST_W-1:0] l1_dist(
    input logic [31:0] a,
    input logic [31:0] b
  );
    logic [npc_pkg::DIST_W-1:0] sum;
    logic [7:0]                 x;
    logic [7:0]                 y;
    sum = '0;
    for (int ch = 0; ch < 4; ch++) begin
      x = a[ch*8 +: 8];
      y = b[ch*8 +: 8];
      sum = sum + npc_pkg::DIST_W'((x > y) ? (x - y) : (y - x));
    end
    return sum;
  endfunction

  for (genvar j = 0; j < NUM_ENTRIES; j++) begin : g_lane
    assign dist_vec[j] = l1_dist(pixel, npc_pkg::PALETTE_ROM[j]);
  end

endmodule

### hdl/npc_top2.sv
// Merge tree that picks the nearest and second-nearest entries, earlier entry on ties.
module npc_top2 #(
  parameter int NUM_ENTRIES = 23
) (
  input  logic [NUM_ENTRIES-1:0][npc_pkg::DIST_W-1:0] dist_vec,
  output npc_pkg::pair_t                               best
);

  // Left operand always covers earlier entries, so strict compares keep list order.
  function automatic npc_pkg::pair_t merge(
    input npc_pkg::pair_t a,
    input npc_pkg::pair_t b
  );
    npc_pkg::pair_t r;
    if (b.first.distance < a.first.distance) begin
      r.first  = b.first;
      r.second = (b.second.distance < a.first.distance) ? b.second : a.first;
    end else begin
      r.first  = a.first;
      r.second = (b.first.distance < a.second.distance) ? b.first : a.second;
    end
    return r;
  endfunction

  npc_pkg::pair_t leaf [npc_pkg::TREE_LEAVES];

  for (genvar j = 0; j < npc_pkg::TREE_LEAVES; j++) begin : g_leaf
    if (j < NUM_ENTRIES) begin : g_real
      assign leaf[j].first.distance = {1'b0, dist_vec[j]};
      assign leaf[j].first.idx      = npc_pkg::IDX_W'(j);
      assign leaf[j].second         = npc_pkg::EMPTY_CAND;
    end else begin : g_pad
      assign leaf[j].first  = npc_pkg::EMPTY_CAND;
      assign leaf[j].second = npc_pkg::EMPTY_CAND;
    end
  end

  always_comb begin
    npc_pkg::pair_t node [npc_pkg::TREE_LEAVES];
    for (int j = 0; j < npc_pkg::TREE_LEAVES; j++) begin
      node[j] = leaf[j];
    end
    // in place: slot k is written only after slots below 2k have been read
    for (int l = 0; l < npc_pkg::TREE_LEVELS; l++) begin
      for (int k = 0; k < (npc_pkg::TREE_LEAVES >> (l + 1)); k++) begin
        node[k] = merge(node[2*k], node[2*k+1]);
      end
    end
    best = node[0];
  end

endmodule

### tb/nearest_palette_color_pair_tb.sv
// Testbench for the nearest palette color pair block: directed, random and stall tests.
module nearest_palette_color_pair_tb;

  localparam int SEARCH_ENTRIES = 23;
  localparam int MAX_GAP        = 16;
  localparam int HOLD_CYCLES    = 80;
  localparam int STALL_LIMIT    = 2000;
  localparam int TAIL_CYCLES    = 8;

  typedef struct {
    logic [31:0]                pixel;
    logic [npc_pkg::IDX_W-1:0]  nearest;
    logic [npc_pkg::IDX_W-1:0]  runner_up;
    logic                       blend;
    logic [npc_pkg::DIST_W-1:0] distance;
  } palette_match_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [31:0]                in_pixel_rgba = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [npc_pkg::IDX_W-1:0]  out_nearest_index;
  logic [npc_pkg::IDX_W-1:0]  out_runner_up_index;
  logic                       out_blend_flag;
  logic [npc_pkg::DIST_W-1:0] out_nearest_distance;

  palette_match_t pending_matches[$];
  int  mismatches = 0;
  int  idle_cycles = 0;
  int  hold_req = 0;
  bit  gaps_off = 1'b0;

  nearest_palette_color_pair #(
    .PALETTE_ENTRIES(SEARCH_ENTRIES)
  ) i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_pixel_rgba       (in_pixel_rgba),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_nearest_index   (out_nearest_index),
    .out_runner_up_index (out_runner_up_index),
    .out_blend_flag      (out_blend_flag),
    .out_nearest_distance(out_nearest_distance)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Linear scan in list order; strict compare keeps the earlier entry on ties.
  function automatic palette_match_t match_palette(logic [31:0] pix);
    palette_match_t m;
    int best1, best2, d, x, y, n;
    best1 = 'hFFFF;
    best2 = 'hFFFF;
    m.pixel = pix;
    m.nearest = '0;
    m.runner_up = '0;
    n = (SEARCH_ENTRIES < npc_pkg::ROM_SIZE) ? SEARCH_ENTRIES : npc_pkg::ROM_SIZE;
    for (int e = 0; e < n; e++) begin
      d = 0;
      for (int c = 0; c < 4; c++) begin
        x = int'(pix[c*8 +: 8]);
        y = int'(npc_pkg::PALETTE_ROM[e][c*8 +: 8]);
        d += (x > y) ? (x - y) : (y - x);
      end
      if (d < best1) begin
        best2 = best1;
        m.runner_up = m.nearest;
        best1 = d;
        m.nearest = npc_pkg::IDX_W'(e);
      end else if (d < best2) begin
        best2 = d;
        m.runner_up = npc_pkg::IDX_W'(e);
      end
    end
    if (best1 > int'(npc_pkg::MAX_DIST)) best1 = 0;
    m.blend = (best2 <= int'(npc_pkg::MAX_DIST)) && (4 * best2 < 9 * best1);
    m.distance = npc_pkg::DIST_W'(best1);
    return m;
  endfunction

  // Called at a rising edge; returns at the edge of the transfer.
  task automatic offer_pixel(logic [31:0] pix);
    int gap;
    gap = gaps_off ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_rgba <= pix;
    do @(posedge clk); while (!in_ready);
    pending_matches.push_back(match_palette(pix));
  endtask

  // Sender pauses until every expected result is back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_matches.size() != 0);
  endtask

  // Pixel halfway between two palette entries, with a little noise.
  function automatic logic [31:0] between_entries();
    logic [31:0] a, b, pix;
    int ch;
    a = npc_pkg::PALETTE_ROM[$urandom_range(0, npc_pkg::ROM_SIZE - 1)];
    b = npc_pkg::PALETTE_ROM[$urandom_range(0, npc_pkg::ROM_SIZE - 1)];
    for (int c = 0; c < 4; c++) begin
      ch = (int'(a[c*8 +: 8]) + int'(b[c*8 +: 8])) / 2 + $urandom_range(0, 8) - 4;
      if (ch < 0) ch = 0;
      if (ch > 255) ch = 255;
      pix[c*8 +: 8] = 8'(ch);
    end
    return pix;
  endfunction

  task automatic test_directed();
    // every entry exactly: zero distance, and the duplicate entries tie
    for (int e = 0; e < npc_pkg::ROM_SIZE; e++) offer_pixel(npc_pkg::PALETTE_ROM[e]);
    offer_pixel(32'hAAAAAAAA);
    offer_pixel(32'h55555555);
    // equidistant from opaque and half-alpha black
    offer_pixel(32'h000000BF);
  endtask

  task automatic test_streaming();
    gaps_off = 1'b1;
    for (int i = 0; i < 100; i++) offer_pixel($urandom());
    gaps_off = 1'b0;
  endtask

  task automatic test_random_gaps();
    for (int i = 0; i < 200; i++) offer_pixel($urandom());
  endtask

  task automatic test_backpressure();
    gaps_off = 1'b1;
    hold_req = HOLD_CYCLES;
    for (int i = 0; i < 40; i++) offer_pixel($urandom());
    gaps_off = 1'b0;
  endtask

  task automatic test_near_boundaries();
    for (int i = 0; i < 160; i++) begin
      if (i % 40 == 0) gaps_off = ~gaps_off;
      offer_pixel(between_entries());
    end
    gaps_off = 1'b0;
  endtask

  initial begin : result_sink
    int stall;
    forever begin
      stall = gaps_off ? 0 : $urandom_range(0, MAX_GAP);
      stall += hold_req;
      hold_req = 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && rst_n));
    end
  end

  always @(posedge clk) begin
    palette_match_t exp_m;
    if (rst_n && out_valid && out_ready) begin
      if (pending_matches.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: nearest %0d runner-up %0d",
                                       out_nearest_index, out_runner_up_index);
      end else begin
        exp_m = pending_matches.pop_front();
        if (out_nearest_index !== exp_m.nearest || out_runner_up_index !== exp_m.runner_up ||
            out_blend_flag !== exp_m.blend || out_nearest_distance !== exp_m.distance) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel %h: expected idx %0d/%0d blend %0b dist %0d, got %0d/%0d %0b %0d",
                     exp_m.pixel, exp_m.nearest, exp_m.runner_up, exp_m.blend, exp_m.distance,
                     out_nearest_index, out_runner_up_index, out_blend_flag,
                     out_nearest_distance);
        end
      end
    end
  end

  // no transfer on either channel for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    drain();
    test_streaming();
    test_random_gaps();
    test_backpressure();
    drain();
    test_near_boundaries();
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    mismatches += pending_matches.size();
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
